@@ hw/rtl/bwhf_pkg.sv @@
package bwhf_pkg;

    localparam int MAX_SIDE = 2048;
    localparam int POS_W = $clog2(MAX_SIDE);
    localparam int LEN_W = POS_W + 1;

    localparam int CFG_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int THR_W = 5;
    localparam int OUT_W = 11;

    localparam int WIN = 5;
    localparam int WIN_BITS = WIN * WIN;
    localparam int HIST_W = WIN - 1;
    localparam int COL_SUM_W = $clog2(WIN + 1);
    localparam int CNT_W = $clog2(WIN_BITS + 1);
    localparam int OFF_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW = 2'd2;

    localparam int SIDE_RST = (MAX_SIDE < 1024) ? MAX_SIDE : 1024;
    localparam int HIGH_RST = 13;
    localparam int LOW_RST = 8;

endpackage

@@ hw/rtl/bwhf_ram.sv @@
module bwhf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/binary_window_hysteresis_filter_top.sv @@
// Binary 5x5 window filter with hysteresis over a square image.
// Input channel: i_valid / o_stall carry one pixel per item in raster order.
// Output channel: o_valid / i_stall carry one filtered pixel per item with its
// row, column and a flag on the last result caused by one input pixel.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 side, 1 high threshold, 2 low threshold); writing the side restarts the
// frame at row 0, column 0. Write only while the block is idle.
// Path: read stage register, then job register, then output register.
// Throughput: one pixel per cycle while each pixel releases at most one
// result and i_stall is low; a pixel ending a row or in the last row releases
// up to three results, the last pixel of the image up to nine, one per cycle
// from the job register; a pixel with results behind the job stalls the input.
// Row history memory: read and written once per pixel, so never a rate limit.
// Reset: position goes to row 0, column 0, registers to their reset values;
// the row history is not cleared, rows above the image are masked.
// Receiver stall: the output register holds, the job waits, and the input
// stalls as soon as the pixel behind the job cannot move on.
module binary_window_hysteresis_filter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_pixel,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bwhf_pkg::OUT_W-1:0]     o_out_row,
    output logic [bwhf_pkg::OUT_W-1:0]     o_out_col,
    output logic                           o_filtered,
    output logic                           o_last_of_run,
    input  logic                           i_cfg_we,
    input  logic [bwhf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bwhf_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [bwhf_pkg::LEN_W-1:0] r_side;
    logic [bwhf_pkg::THR_W-1:0] r_high;
    logic [bwhf_pkg::THR_W-1:0] r_low;
    logic [bwhf_pkg::POS_W-1:0] n_m1;

    logic [bwhf_pkg::POS_W-1:0] r_in_row;
    logic [bwhf_pkg::POS_W-1:0] r_in_col;
    logic                       acc;

    logic                        r_s1_valid;
    logic [bwhf_pkg::POS_W-1:0]  r_s1_row;
    logic [bwhf_pkg::POS_W-1:0]  r_s1_col;
    logic                        r_s1_pix;
    logic                        s1_adv;
    logic                        s1_has;
    logic                        s1_last_row;
    logic                        s1_last_col;
    logic [bwhf_pkg::OFF_W-1:0]  s1_dr_start;
    logic [bwhf_pkg::OFF_W-1:0]  s1_dc_start;

    logic [bwhf_pkg::HIST_W-1:0] ram_rdata;
    logic                        r_fwd_hit;
    logic [bwhf_pkg::HIST_W-1:0] r_fwd_data;
    logic [bwhf_pkg::HIST_W-1:0] hist;
    logic [bwhf_pkg::WIN-1:0]    vec;

    logic [bwhf_pkg::WIN_BITS-1:0] r_win;
    logic [bwhf_pkg::WIN_BITS-1:0] n_win;

    logic                          r_job_valid;
    logic [bwhf_pkg::WIN_BITS-1:0] r_job_win;
    logic [bwhf_pkg::POS_W-1:0]    r_job_row;
    logic [bwhf_pkg::POS_W-1:0]    r_job_col;
    logic [bwhf_pkg::OFF_W-1:0]    r_job_dr;
    logic [bwhf_pkg::OFF_W-1:0]    r_job_dc;
    logic [bwhf_pkg::OFF_W-1:0]    r_job_dc_start;
    logic [bwhf_pkg::OFF_W-1:0]    r_job_dr_end;
    logic [bwhf_pkg::OFF_W-1:0]    r_job_dc_end;
    logic                          job_last;
    logic                          job_done;
    logic                          job_free;

    logic                        r_o_valid;
    logic [bwhf_pkg::OUT_W-1:0]  r_o_row;
    logic [bwhf_pkg::OUT_W-1:0]  r_o_col;
    logic                        r_o_filt;
    logic                        r_o_last;
    logic                        o_load;

    logic [bwhf_pkg::WIN-1:0]    col_ok;
    logic [bwhf_pkg::WIN-1:0]    row_ok;
    logic [bwhf_pkg::CNT_W-1:0]  count;
    logic                        center;
    logic                        filt;

    assign n_m1 = bwhf_pkg::POS_W'(r_side - bwhf_pkg::LEN_W'(1));

    // configuration and input position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= bwhf_pkg::LEN_W'(bwhf_pkg::SIDE_RST);
            r_high <= bwhf_pkg::THR_W'(bwhf_pkg::HIGH_RST);
            r_low <= bwhf_pkg::THR_W'(bwhf_pkg::LOW_RST);
            r_in_row <= '0;
            r_in_col <= '0;
        end else begin
            if (acc) begin
                if (r_in_col == n_m1) begin
                    r_in_col <= '0;
                    r_in_row <= (r_in_row == n_m1) ? '0
                        : r_in_row + bwhf_pkg::POS_W'(1);
                end else begin
                    r_in_col <= r_in_col + bwhf_pkg::POS_W'(1);
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bwhf_pkg::REG_SIDE: begin
                        if (i_cfg_data == '0) begin
                            r_side <= bwhf_pkg::LEN_W'(1);
                        end else if (int'(i_cfg_data) > bwhf_pkg::MAX_SIDE) begin
                            r_side <= bwhf_pkg::LEN_W'(bwhf_pkg::MAX_SIDE);
                        end else begin
                            r_side <= bwhf_pkg::LEN_W'(i_cfg_data);
                        end
                        r_in_row <= '0;
                        r_in_col <= '0;
                    end
                    bwhf_pkg::REG_HIGH: begin
                        r_high <= i_cfg_data[bwhf_pkg::THR_W-1:0];
                    end
                    bwhf_pkg::REG_LOW: begin
                        r_low <= i_cfg_data[bwhf_pkg::THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_stall = r_s1_valid && !s1_adv;
    assign acc = i_valid && !o_stall;

    // read stage: history of the column arrives in the cycle after acceptance
    bwhf_ram #(
        .WIDTH(bwhf_pkg::HIST_W),
        .DEPTH(bwhf_pkg::MAX_SIDE)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (s1_adv),
        .i_waddr(r_s1_col),
        .i_wdata(vec[bwhf_pkg::WIN-1:1]),
        .i_re   (acc),
        .i_raddr(r_in_col),
        .o_rdata(ram_rdata)
    );

    assign hist = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign vec = {r_s1_pix, hist};
    assign n_win = {vec, r_win[bwhf_pkg::WIN_BITS-1:bwhf_pkg::WIN]};

    assign s1_last_row = (r_s1_row == n_m1);
    assign s1_last_col = (r_s1_col == n_m1);
    assign s1_has = (s1_last_row || r_s1_row >= bwhf_pkg::POS_W'(2))
        && (s1_last_col || r_s1_col >= bwhf_pkg::POS_W'(2));
    assign s1_dr_start = (s1_last_row && r_s1_row < bwhf_pkg::POS_W'(2))
        ? r_s1_row[bwhf_pkg::OFF_W-1:0] : bwhf_pkg::OFF_W'(2);
    assign s1_dc_start = (s1_last_col && r_s1_col < bwhf_pkg::POS_W'(2))
        ? r_s1_col[bwhf_pkg::OFF_W-1:0] : bwhf_pkg::OFF_W'(2);
    assign s1_adv = r_s1_valid && (!s1_has || job_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_row <= r_in_row;
            r_s1_col <= r_in_col;
            r_s1_pix <= i_pixel;
            r_fwd_hit <= s1_adv && (r_s1_col == r_in_col);
            r_fwd_data <= vec[bwhf_pkg::WIN-1:1];
        end
        if (s1_adv) begin
            r_win <= n_win;
        end
    end

    // job register: walks the results released by one pixel
    assign job_last = (r_job_dr == r_job_dr_end) && (r_job_dc == r_job_dc_end);
    assign o_load = r_job_valid && (!r_o_valid || !i_stall);
    assign job_done = o_load && job_last;
    assign job_free = !r_job_valid || job_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (s1_adv && s1_has) begin
            r_job_valid <= 1'b1;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_has) begin
            r_job_win <= n_win;
            r_job_row <= r_s1_row;
            r_job_col <= r_s1_col;
            r_job_dr <= s1_dr_start;
            r_job_dc <= s1_dc_start;
            r_job_dc_start <= s1_dc_start;
            r_job_dr_end <= s1_last_row ? '0 : bwhf_pkg::OFF_W'(2);
            r_job_dc_end <= s1_last_col ? '0 : bwhf_pkg::OFF_W'(2);
        end else if (o_load && !job_last) begin
            if (r_job_dc == r_job_dc_end) begin
                r_job_dc <= r_job_dc_start;
                r_job_dr <= r_job_dr - bwhf_pkg::OFF_W'(1);
            end else begin
                r_job_dc <= r_job_dc - bwhf_pkg::OFF_W'(1);
            end
        end
    end

    // masked window count of the current result
    always_comb begin
        logic [bwhf_pkg::COL_SUM_W-1:0] col_sum;
        count = '0;
        center = 1'b0;
        for (int w = 0; w < bwhf_pkg::WIN; w++) begin
            col_ok[w] = (int'(r_job_dc) + w >= 2)
                && (int'(r_job_col) >= bwhf_pkg::WIN - 1 - w);
            row_ok[w] = (int'(r_job_dr) + w >= 2)
                && (int'(r_job_row) >= bwhf_pkg::WIN - 1 - w);
        end
        for (int w = 0; w < bwhf_pkg::WIN; w++) begin
            col_sum = '0;
            for (int b = 0; b < bwhf_pkg::WIN; b++) begin
                col_sum = col_sum + bwhf_pkg::COL_SUM_W'(
                    r_job_win[w * bwhf_pkg::WIN + b] & col_ok[w] & row_ok[b]);
                if (w == bwhf_pkg::WIN - 1 - int'(r_job_dc)
                    && b == bwhf_pkg::WIN - 1 - int'(r_job_dr)) begin
                    center = r_job_win[w * bwhf_pkg::WIN + b];
                end
            end
            count = count + bwhf_pkg::CNT_W'(col_sum);
        end
        if (count > bwhf_pkg::CNT_W'(r_high)) begin
            filt = 1'b1;
        end else if (count < bwhf_pkg::CNT_W'(r_low)) begin
            filt = 1'b0;
        end else begin
            filt = center;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_row <= bwhf_pkg::OUT_W'(r_job_row - bwhf_pkg::POS_W'(r_job_dr));
            r_o_col <= bwhf_pkg::OUT_W'(r_job_col - bwhf_pkg::POS_W'(r_job_dc));
            r_o_filt <= filt;
            r_o_last <= job_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_out_row = r_o_row;
    assign o_out_col = r_o_col;
    assign o_filtered = r_o_filt;
    assign o_last_of_run = r_o_last;

    a_job_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_job_dr >= r_job_dr_end) && (r_job_dc >= r_job_dc_end))
        else $error("job offsets passed their end");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_col) && $stable(r_s1_row))
        else $error("blocked pixel lost its position");

    a_out_from_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_job_valid))
        else $error("result shown without a job");

endmodule

@@ tb/tb.sv @@
module tb;

    localparam logic [bwhf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 296;

    typedef struct {
        logic [bwhf_pkg::OUT_W-1:0] row;
        logic [bwhf_pkg::OUT_W-1:0] col;
        logic                       value;
        logic                       run_end;
    } t_filtered_pixel;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic                           i_pixel = 1'b0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [bwhf_pkg::OUT_W-1:0]     o_out_row;
    logic [bwhf_pkg::OUT_W-1:0]     o_out_col;
    logic                           o_filtered;
    logic                           o_last_of_run;
    logic                           i_cfg_we = 1'b0;
    logic [bwhf_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [bwhf_pkg::CFG_W-1:0]     i_cfg_data = '0;

    binary_window_hysteresis_filter_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_filtered    (o_filtered),
        .o_last_of_run (o_last_of_run),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // filter state mirror
    logic [bwhf_pkg::HIST_W-1:0] hist_mem [bwhf_pkg::MAX_SIDE];
    logic [bwhf_pkg::WIN-1:0]    col_win [bwhf_pkg::WIN];
    int                          cur_row;
    int                          cur_col;
    logic [bwhf_pkg::CFG_W-1:0]  cfg_side;
    logic [bwhf_pkg::THR_W-1:0]  thr_high;
    logic [bwhf_pkg::THR_W-1:0]  thr_low;

    t_filtered_pixel   filtered_due[$];
    int                mismatch_count = 0;
    int                in_gap_max = 16;
    int                out_gap_max = 16;
    int                long_hold = 0;
    int                cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void reset_filter_state();
        for (int k = 0; k < bwhf_pkg::MAX_SIDE; k++) hist_mem[k] = '0;
        for (int k = 0; k < bwhf_pkg::WIN; k++) col_win[k] = '0;
        cur_row = 0;
        cur_col = 0;
        cfg_side = bwhf_pkg::CFG_W'(bwhf_pkg::SIDE_RST);
        thr_high = bwhf_pkg::THR_W'(bwhf_pkg::HIGH_RST);
        thr_low = bwhf_pkg::THR_W'(bwhf_pkg::LOW_RST);
    endfunction

    function automatic int eff_side();
        int s;
        s = int'(cfg_side);
        if (s < 1) s = 1;
        if (s > bwhf_pkg::MAX_SIDE) s = bwhf_pkg::MAX_SIDE;
        return s;
    endfunction

    // vote of the 5x5 window around (r, c) while pixel (i, j) is newest
    function automatic logic window_vote(int r, int c, int i, int j, int n);
        int q0, q1, k0, k1, k, q, w, b, count;
        q0 = (r - 2 < 0) ? 0 : r - 2;
        q1 = (r + 2 > n - 1) ? n - 1 : r + 2;
        k0 = (c - 2 < 0) ? 0 : c - 2;
        k1 = (c + 2 > n - 1) ? n - 1 : c + 2;
        count = 0;
        for (k = k0; k <= k1; k++) begin
            w = 4 - (j - k);
            if (w >= 0 && w <= 4) begin
                for (q = q0; q <= q1; q++) begin
                    b = q - (i - 4);
                    if (b >= 0 && b <= 4) count += int'(col_win[w][b]);
                end
            end
        end
        if (count > int'(thr_high)) return 1'b1;
        if (count < int'(thr_low)) return 1'b0;
        w = 4 - (j - c);
        b = r - (i - 4);
        if (w < 0 || w > 4 || b < 0 || b > 4) return 1'b0;
        return col_win[w][b];
    endfunction

    function automatic void predict_filter(logic p);
        int n, i, j, r0, r1, c0, c1, r, c, w;
        logic [bwhf_pkg::WIN-1:0] vec;
        t_filtered_pixel res;
        n = eff_side();
        i = cur_row;
        j = cur_col;
        if (i >= n || j >= n) begin
            i = 0;
            j = 0;
        end
        vec = {p, hist_mem[j]};
        hist_mem[j] = vec[bwhf_pkg::WIN-1:1];
        for (w = 0; w < bwhf_pkg::WIN - 1; w++) col_win[w] = col_win[w+1];
        col_win[bwhf_pkg::WIN-1] = vec;
        if (i + 1 < n) begin
            r0 = i - 2;
            r1 = i - 2;
        end else begin
            r0 = (n >= 3) ? n - 3 : 0;
            r1 = n - 1;
        end
        if (j + 1 < n) begin
            c0 = j - 2;
            c1 = j - 2;
        end else begin
            c0 = (n >= 3) ? n - 3 : 0;
            c1 = n - 1;
        end
        if (r0 >= 0 && c0 >= 0) begin
            for (r = r0; r <= r1; r++) begin
                for (c = c0; c <= c1; c++) begin
                    res.row = bwhf_pkg::OUT_W'(r);
                    res.col = bwhf_pkg::OUT_W'(c);
                    res.value = window_vote(r, c, i, j, n);
                    res.run_end = (r == r1 && c == c1);
                    filtered_due.push_back(res);
                end
            end
        end
        j++;
        if (j >= n) begin
            j = 0;
            i++;
            if (i >= n) i = 0;
        end
        cur_row = i;
        cur_col = j;
    endfunction

    function automatic void apply_reg(logic [bwhf_pkg::CFG_IDX_W-1:0] idx,
                                      logic [bwhf_pkg::CFG_W-1:0] data);
        case (idx)
            bwhf_pkg::REG_SIDE: begin
                cfg_side = data;
                cur_row = 0;
                cur_col = 0;
            end
            bwhf_pkg::REG_HIGH: thr_high = data[bwhf_pkg::THR_W-1:0];
            bwhf_pkg::REG_LOW:  thr_low = data[bwhf_pkg::THR_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0d] check failed: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_filtered_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (filtered_due.size() == 0) begin
                report_mismatch($sformatf("unexpected item row %0d col %0d",
                                          o_out_row, o_out_col));
            end else begin
                want = filtered_due.pop_front();
                if (o_out_row !== want.row)
                    report_mismatch($sformatf("row %0d, want %0d", o_out_row, want.row));
                if (o_out_col !== want.col)
                    report_mismatch($sformatf("col %0d, want %0d", o_out_col, want.col));
                if (o_filtered !== want.value)
                    report_mismatch($sformatf("value %b at (%0d,%0d), want %b",
                                              o_filtered, want.row, want.col, want.value));
                if (o_last_of_run !== want.run_end)
                    report_mismatch($sformatf("last flag %b at (%0d,%0d), want %b",
                                              o_last_of_run, want.row, want.col,
                                              want.run_end));
            end
        end
    end

    // result side: random hold-off per item, plus one long hold on request
    initial begin
        int gap;
        forever begin
            gap = (out_gap_max > 0) ? $urandom_range(out_gap_max, 0) : 0;
            if (long_hold > 0) begin
                gap = long_hold;
                long_hold = 0;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    task automatic send_pixel(input logic p);
        int gap;
        gap = (in_gap_max > 0) ? $urandom_range(in_gap_max, 0) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_filter(p);
    endtask

    task automatic settle_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (filtered_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bwhf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bwhf_pkg::CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic [bwhf_pkg::CFG_W-1:0] pick_threshold();
        if ($urandom_range(7, 0) == 0) return bwhf_pkg::CFG_W'($urandom_range(31, 26));
        return bwhf_pkg::CFG_W'($urandom_range(25, 0));
    endfunction

    task automatic test_reset_defaults();
        logic [15:0] pattern;
        pattern = 16'hF7B3;
        // default side gives no item in the first rows
        repeat (3) send_pixel(1'b1);
        settle_block();
        write_reg(bwhf_pkg::REG_SIDE, bwhf_pkg::CFG_W'(4));
        for (int k = 0; k < 16; k++) send_pixel(pattern[k]);
        settle_block();
    endtask

    task automatic test_side_one();
        write_reg(bwhf_pkg::REG_SIDE, '0);
        write_reg(bwhf_pkg::REG_HIGH, '0);
        write_reg(bwhf_pkg::REG_LOW, bwhf_pkg::CFG_W'(31));
        send_pixel(1'b1);
        send_pixel(1'b0);
        settle_block();
        write_reg(bwhf_pkg::REG_HIGH, bwhf_pkg::CFG_W'(31));
        write_reg(bwhf_pkg::REG_LOW, '0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        settle_block();
        write_reg(REG_SPARE, '1);
        send_pixel(1'b1);
        settle_block();
    endtask

    task automatic test_side_clamp_restart();
        write_reg(bwhf_pkg::REG_SIDE, '1);
        send_pixel(1'b1);
        send_pixel(1'b0);
        settle_block();
        // restart in the middle of a frame
        write_reg(bwhf_pkg::REG_SIDE, bwhf_pkg::CFG_W'(2));
        write_reg(bwhf_pkg::REG_HIGH, bwhf_pkg::CFG_W'(2));
        write_reg(bwhf_pkg::REG_LOW, bwhf_pkg::CFG_W'(1));
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b0);
        settle_block();
    endtask

    task automatic test_backpressure();
        write_reg(bwhf_pkg::REG_SIDE, bwhf_pkg::CFG_W'(8));
        write_reg(bwhf_pkg::REG_HIGH, bwhf_pkg::CFG_W'(12));
        write_reg(bwhf_pkg::REG_LOW, bwhf_pkg::CFG_W'(6));
        in_gap_max = 0;
        out_gap_max = 0;
        long_hold = 300;
        repeat (64) send_pixel($urandom_range(99, 0) < 55);
        settle_block();
        out_gap_max = 16;
        repeat (40) send_pixel(1'($urandom_range(1, 0)));
        settle_block();
    endtask

    task automatic test_random_frames();
        int side, count, density, total;
        total = 0;
        while (total < RANDOM_ITEMS) begin
            settle_block();
            side = ($urandom_range(7, 0) == 0) ? $urandom_range(16, 10)
                : $urandom_range(9, 1);
            write_reg(bwhf_pkg::REG_SIDE, bwhf_pkg::CFG_W'(side));
            write_reg(bwhf_pkg::REG_HIGH, pick_threshold());
            write_reg(bwhf_pkg::REG_LOW, pick_threshold());
            in_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 16;
            out_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 16;
            case ($urandom_range(4, 0))
                0: density = 0;
                1: density = 100;
                default: density = $urandom_range(100, 0);
            endcase
            case ($urandom_range(5, 0))
                0: count = $urandom_range(side * side, 1);
                1: count = side * side + $urandom_range(side * side, 1);
                default: count = side * side;
            endcase
            if (count > RANDOM_ITEMS - total) count = RANDOM_ITEMS - total;
            repeat (count) send_pixel($urandom_range(99, 0) < density);
            total += count;
        end
        in_gap_max = 16;
        out_gap_max = 16;
    endtask

    initial begin
        reset_filter_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_side_one();
        test_side_clamp_restart();
        test_backpressure();
        test_random_frames();
        settle_block();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bwhf_pkg.sv
hw/rtl/bwhf_ram.sv
hw/rtl/binary_window_hysteresis_filter_top.sv
tb/tb.sv
